[src/bcle_pkg.sv]
package bcle_pkg;

  // Low buttons that are logged, and the ceiling of the frame gap counter.
  localparam int unsigned RecBtn = 12;
  localparam int unsigned MaxGap = 13274;
  localparam int unsigned ResultLimit = 64;

  localparam int unsigned BtnW = 16;
  localparam int unsigned GapW = 14;
  localparam int unsigned IdxW = 4;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CntW = $clog2(ResultLimit + 1);
  localparam int unsigned PcW = 3;

  localparam logic [GapW-1:0] GapNibMax = GapW'(15);
  localparam logic [GapW-1:0] RunByte = GapW'(255);
  localparam logic [GapW-1:0] GapCeil = GapW'(MaxGap);

  // Program step addresses.
  localparam logic [PcW-1:0] StepWait = PcW'(0);
  localparam logic [PcW-1:0] StepScan = PcW'(1);
  localparam logic [PcW-1:0] StepHdr = PcW'(2);
  localparam logic [PcW-1:0] StepRun = PcW'(3);
  localparam logic [PcW-1:0] StepNext = PcW'(4);
  localparam logic [PcW-1:0] StepDone = PcW'(5);

  typedef enum logic [2:0] {
    ActLoad,
    ActScan,
    ActHdr,
    ActRun,
    ActNext,
    ActDone
  } act_e;

  typedef enum logic [2:0] {
    CondAlways,
    CondInValid,
    CondPendZero,
    CondGapLt15,
    CondRestLt255
  } cond_e;

  typedef struct packed {
    act_e           act;
    cond_e          cond;
    logic [PcW-1:0] jmp_t;
    logic [PcW-1:0] jmp_f;
  } uword_t;

  // Control handed from the sequencer to the datapath.
  typedef struct packed {
    act_e act;
    logic en;
  } ctl_t;

  // Flags handed from the datapath back to the sequencer.
  typedef struct packed {
    logic in_valid;
    logic pend_zero;
    logic gap_lt15;
    logic rest_lt255;
    logic emit_ok;
  } status_t;

  function automatic uword_t ucode(logic [PcW-1:0] pc);
    uword_t w;
    case (pc)
      StepWait: w = '{ActLoad, CondInValid, StepScan, StepWait};
      StepScan: w = '{ActScan, CondPendZero, StepDone, StepHdr};
      StepHdr:  w = '{ActHdr, CondGapLt15, StepNext, StepRun};
      StepRun:  w = '{ActRun, CondRestLt255, StepNext, StepRun};
      StepNext: w = '{ActNext, CondAlways, StepScan, StepScan};
      StepDone: w = '{ActDone, CondAlways, StepWait, StepWait};
      default:  w = '{ActLoad, CondInValid, StepScan, StepWait};
    endcase
    return w;
  endfunction

endpackage

[src/bcle_seq.sv]
module bcle_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bcle_pkg::status_t stat_i,
  output bcle_pkg::ctl_t    ctl_o
);

  logic [bcle_pkg::PcW-1:0] pc_q, pc_d;
  bcle_pkg::uword_t         uw;
  logic                     cond_hit;
  logic                     en;

  assign uw = bcle_pkg::ucode(pc_q);

  always_comb begin
    case (uw.cond)
      bcle_pkg::CondAlways:    cond_hit = 1'b1;
      bcle_pkg::CondInValid:   cond_hit = stat_i.in_valid;
      bcle_pkg::CondPendZero:  cond_hit = stat_i.pend_zero;
      bcle_pkg::CondGapLt15:   cond_hit = stat_i.gap_lt15;
      bcle_pkg::CondRestLt255: cond_hit = stat_i.rest_lt255;
      default:                 cond_hit = 1'b1;
    endcase
  end

  // Emitting steps wait for room in the output register; the load step
  // waits for an input beat.
  always_comb begin
    case (uw.act)
      bcle_pkg::ActLoad: en = stat_i.in_valid;
      bcle_pkg::ActHdr:  en = stat_i.emit_ok;
      bcle_pkg::ActRun:  en = stat_i.emit_ok;
      default:           en = 1'b1;
    endcase
  end

  assign pc_d = en ? (cond_hit ? uw.jmp_t : uw.jmp_f) : pc_q;
  assign ctl_o = '{act: uw.act, en: en};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= bcle_pkg::StepWait;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

[src/bcle_dp.sv]
module bcle_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bcle_pkg::ctl_t              ctl_i,
  output bcle_pkg::status_t           stat_o,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [bcle_pkg::BtnW-1:0]   buttons_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bcle_pkg::ByteW-1:0]  log_byte_o,
  output logic                        last_byte_o
);

  logic [bcle_pkg::BtnW-1:0]   prev_q;
  logic [bcle_pkg::GapW-1:0]   gap_q;
  logic [bcle_pkg::GapW-1:0]   rest_q;
  logic [bcle_pkg::RecBtn-1:0] pend_q;
  logic [bcle_pkg::IdxW-1:0]   idx_q;
  logic [bcle_pkg::CntW-1:0]   cnt_q;
  logic                        ov_q;
  logic [bcle_pkg::ByteW-1:0]  byte_q;
  logic                        last_q;

  logic [bcle_pkg::BtnW-1:0]   diff;
  logic [bcle_pkg::RecBtn-1:0] pend_rest;
  logic                        more_bits;
  logic [bcle_pkg::IdxW-1:0]   low_idx;
  logic                        gap_lt15;
  logic                        rest_lt255;
  logic                        room;
  logic                        emit;
  logic                        at_cap;
  logic [bcle_pkg::ByteW-1:0]  emit_byte;
  logic                        emit_more;

  assign diff = buttons_i ^ prev_q;
  // Pending changes above the one being logged now.
  assign pend_rest = pend_q & (pend_q - bcle_pkg::RecBtn'(1));
  assign more_bits = |pend_rest;
  assign gap_lt15 = gap_q < bcle_pkg::GapNibMax;
  assign rest_lt255 = rest_q < bcle_pkg::RunByte;
  assign at_cap = cnt_q == bcle_pkg::CntW'(bcle_pkg::ResultLimit);
  assign room = !ov_q || out_ready_i;

  always_comb begin
    low_idx = '0;
    for (int i = bcle_pkg::RecBtn - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        low_idx = bcle_pkg::IdxW'(i);
      end
    end
  end

  always_comb begin
    if (ctl_i.act == bcle_pkg::ActHdr) begin
      emit_byte = {idx_q, gap_lt15 ? gap_q[3:0] : 4'hF};
      emit_more = !gap_lt15 || more_bits;
    end else if (!rest_lt255) begin
      emit_byte = 8'hFF;
      emit_more = 1'b1;
    end else begin
      emit_byte = rest_q[bcle_pkg::ByteW-1:0];
      emit_more = more_bits;
    end
  end

  assign emit = ctl_i.en && !at_cap &&
                (ctl_i.act == bcle_pkg::ActHdr || ctl_i.act == bcle_pkg::ActRun);

  assign stat_o = '{in_valid: in_valid_i, pend_zero: pend_q == '0, gap_lt15: gap_lt15,
                    rest_lt255: rest_lt255, emit_ok: at_cap || room};

  assign in_ready_o = ctl_i.act == bcle_pkg::ActLoad;
  assign out_valid_o = ov_q;
  assign log_byte_o = byte_q;
  assign last_byte_o = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      gap_q <= '0;
      pend_q <= '0;
      cnt_q <= '0;
      ov_q <= 1'b0;
    end else begin
      if (ctl_i.en) begin
        case (ctl_i.act)
          bcle_pkg::ActLoad: begin
            if (diff != '0) begin
              prev_q <= buttons_i;
            end
            pend_q <= diff[bcle_pkg::RecBtn-1:0];
            cnt_q <= '0;
          end
          bcle_pkg::ActNext: begin
            gap_q <= '0;
            pend_q <= pend_rest;
          end
          bcle_pkg::ActDone: begin
            if (gap_q < bcle_pkg::GapCeil) begin
              gap_q <= gap_q + bcle_pkg::GapW'(1);
            end
          end
          default: begin
          end
        endcase
      end
      if (emit) begin
        cnt_q <= cnt_q + bcle_pkg::CntW'(1);
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en && ctl_i.act == bcle_pkg::ActScan) begin
      idx_q <= low_idx;
    end
    if (ctl_i.en && ctl_i.act == bcle_pkg::ActHdr) begin
      rest_q <= gap_q - bcle_pkg::GapNibMax;
    end else if (ctl_i.en && ctl_i.act == bcle_pkg::ActRun && !rest_lt255) begin
      rest_q <= rest_q - bcle_pkg::RunByte;
    end
    if (emit) begin
      byte_q <= emit_byte;
      last_q <= !emit_more ||
                cnt_q == bcle_pkg::CntW'(bcle_pkg::ResultLimit - 1);
    end
  end

  a_gap_ceil: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gap_q <= bcle_pkg::GapCeil)
    else $error("frame gap above its ceiling");

  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= bcle_pkg::CntW'(bcle_pkg::ResultLimit))
    else $error("byte count above the per-frame limit");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> ov_q)
    else $error("emitted byte did not reach the output register");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready_i) |-> !emit)
    else $error("output register overwritten while stalled");

endmodule

[src/button_change_log_encoder_core.sv]
// Button change log encoder.
// The slave channel takes one beat per video frame: tdata[15:0] is the
// controller word. The word is compared with the stored one; for each changed
// button among the low twelve, lowest first, the master channel sends a header
// byte (button index in the high nibble, frame gap capped at 15 in the low
// nibble), and when the gap is 15 or more, a run of 0xFF bytes and a final
// remainder byte. tlast marks the final byte that a frame produces; a frame
// with no logged change produces no beat at all.
// Control is a six-step microprogram: load, scan for the next changed bit,
// header, run bytes, clear, gap update. The first byte of a frame is
// registered in the header step, which follows the load and scan steps; the
// output register can take a new byte while its previous one leaves, and a
// stalled receiver holds the sequencer at its current byte. tready on the
// slave side is high only in the load step, so a frame is taken while the
// last byte of the previous one still waits.
// Reset clears the stored word, the gap counter and the output valid flag.
module button_change_log_encoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [15:0] buttons
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // [7:0] log_byte
  output logic        m_axis_tlast_o   // last_byte
);

  bcle_pkg::ctl_t    ctl;
  bcle_pkg::status_t stat;

  // Step counter and control store.
  bcle_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  // Stored word, gap counter, pending changes and the output register.
  bcle_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .stat_o      (stat),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .buttons_i   (s_axis_tdata_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .log_byte_o  (m_axis_tdata_o),
    .last_byte_o (m_axis_tlast_o)
  );

endmodule

[bench/tb_top.sv]
module tb_top;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned GapNib = 15;
  localparam int unsigned RunVal = 255;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned RandFrames = 100;

  typedef struct packed {
    logic [bcle_pkg::ByteW-1:0] log_byte;
    logic                       last_byte;
  } log_beat_t;

  // One row of the directed table. n_fix > 0 means the bytes are typed in:
  // fix[7:0] first, then fix[15:8], then fix[23:16]; tlast on the final one.
  typedef struct packed {
    logic [bcle_pkg::BtnW-1:0] btn;
    logic [15:0]               reps;
    logic [1:0]                n_fix;
    logic [23:0]               fix;
  } stim_row_t;

  localparam int unsigned NumRows = 18;
  localparam stim_row_t DirRows [NumRows] = '{
    '{16'h0001, 16'd1, 2'd1, 24'h000000},  // first change after reset, gap zero
    '{16'h0001, 16'd1, 2'd0, 24'h000000},  // no change
    '{16'hF001, 16'd1, 2'd0, 24'h000000},  // upper buttons only
    '{16'h0FFE, 16'd1, 2'd0, 24'h000000},  // all twelve logged buttons flip
    '{16'h0FFE, 16'd14, 2'd0, 24'h000000}, // gap climbs to 15
    '{16'h0FFF, 16'd1, 2'd2, 24'h00000F},  // gap exactly 15: header and zero
    '{16'h0FFF, 16'd269, 2'd0, 24'h000000},
    '{16'h0FFE, 16'd1, 2'd3, 24'h00FF0F},  // gap 270: one run byte
    '{16'h07FE, 16'd1, 2'd1, 24'h0000B1},  // top logged button
    '{16'hF7FE, 16'd1, 2'd0, 24'h000000},  // upper buttons only
    '{16'h0000, 16'd1, 2'd0, 24'h000000},
    '{16'h0000, 16'd13300, 2'd0, 24'h000000}, // gap counter saturates
    '{16'h0FFF, 16'd1, 2'd0, 24'h000000},  // longest frame: 64 bytes
    '{16'hFFFF, 16'd1, 2'd0, 24'h000000},
    '{16'h0000, 16'd1, 2'd0, 24'h000000},
    '{16'h5555, 16'd1, 2'd0, 24'h000000},
    '{16'hAAAA, 16'd1, 2'd0, 24'h000000},
    '{16'hFFFF, 16'd1, 2'd0, 24'h000000}
  };

  logic                       clk_i = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       s_tvalid = 1'b0;
  logic [bcle_pkg::BtnW-1:0]  s_tdata = '0;
  logic                       m_tready = 1'b0;
  logic                       s_axis_tready_o;
  logic                       m_axis_tvalid_o;
  logic [bcle_pkg::ByteW-1:0] m_axis_tdata_o;
  logic                       m_axis_tlast_o;

  // Predictor state.
  logic [bcle_pkg::BtnW-1:0]  stored_btn = '0;
  int unsigned                gap_cnt = 0;
  log_beat_t                  frame_bytes[$];
  log_beat_t                  expected_bytes[$];

  logic              calm = 1'b0;
  logic              hold_req = 1'b0;
  logic              rx_hold = 1'b0;
  int unsigned       rx_wait = 0;
  int unsigned       mismatches = 0;
  int unsigned       frames_sent = 0;
  int unsigned       beats_checked = 0;
  int unsigned       cycles = 0;

  button_change_log_encoder_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d bytes still expected", cycles,
               expected_bytes.size());
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  function automatic void add_byte(input logic [bcle_pkg::ByteW-1:0] value);
    log_beat_t b;
    b.log_byte = value;
    b.last_byte = 1'b0;
    if (frame_bytes.size() < bcle_pkg::ResultLimit) frame_bytes = {frame_bytes, b};
  endfunction

  // Builds the bytes one frame produces and advances the stored word and gap.
  task automatic encode_frame(input logic [bcle_pkg::BtnW-1:0] btn);
    logic [bcle_pkg::BtnW-1:0] diff;
    int unsigned               rest;
    int unsigned               low_gap;
    diff = btn ^ stored_btn;
    frame_bytes.delete();
    if (diff != '0) begin
      stored_btn = btn;
      for (int i = 0; i < bcle_pkg::RecBtn; i++) begin
        if (diff[i]) begin
          low_gap = (gap_cnt < GapNib) ? gap_cnt : GapNib;
          add_byte(bcle_pkg::ByteW'((i << 4) | low_gap));
          if (gap_cnt >= GapNib) begin
            rest = gap_cnt - GapNib;
            while (rest >= RunVal) begin
              add_byte(bcle_pkg::ByteW'(RunVal));
              rest -= RunVal;
            end
            add_byte(bcle_pkg::ByteW'(rest));
          end
          gap_cnt = 0;
        end
      end
    end
    if (gap_cnt < bcle_pkg::MaxGap) gap_cnt++;
    if (frame_bytes.size() > 0) frame_bytes[frame_bytes.size() - 1].last_byte = 1'b1;
  endtask

  // Offers one frame word after a random gap and waits for the slave beat.
  task automatic send_frame(input logic [bcle_pkg::BtnW-1:0] btn);
    int unsigned w;
    w = calm ? 0 : $urandom_range(0, 5);
    if (w > 0) begin
      s_tvalid <= 1'b0;
      repeat (w) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= btn;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    frames_sent++;
    encode_frame(btn);
  endtask

  task automatic queue_frame_bytes();
    foreach (frame_bytes[k]) expected_bytes = {expected_bytes, frame_bytes[k]};
  endtask

  task automatic wait_drained();
    while (expected_bytes.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stalls per beat, plus the long hold-off when requested.
  always @(posedge clk_i or negedge rst_n) begin
    int unsigned w;
    log_beat_t   exp_b;
    if (!rst_n) begin
      m_tready <= 1'b0;
      rx_wait <= 0;
    end else begin
      w = rx_wait;
      if (m_axis_tvalid_o && m_tready) begin
        beats_checked++;
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last %0b",
                                    m_axis_tdata_o, m_axis_tlast_o));
        end else begin
          exp_b = expected_bytes.pop_front();
          if (m_axis_tdata_o !== exp_b.log_byte)
            report_mismatch($sformatf("log_byte %02h, expected %02h",
                                      m_axis_tdata_o, exp_b.log_byte));
          if (m_axis_tlast_o !== exp_b.last_byte)
            report_mismatch($sformatf("last_byte %0b, expected %0b (byte %02h)",
                                      m_axis_tlast_o, exp_b.last_byte, exp_b.log_byte));
        end
        w = calm ? 0 : $urandom_range(0, 5);
      end else if (w > 0 && !rx_hold) begin
        w = w - 1;
      end
      rx_wait <= w;
      m_tready <= (w == 0) && !rx_hold;
    end
  end

  // Long receiver hold-off, timed here so the sender keeps offering frames.
  initial begin
    wait (hold_req);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    stim_row_t                 row;
    log_beat_t                 b;
    logic [bcle_pkg::BtnW-1:0] btn;
    int unsigned               kind;
    int unsigned               counted;
    int unsigned               stretch;

    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    for (int r = 0; r < NumRows; r++) begin
      row = DirRows[r];
      calm = (row.reps > 100);
      for (int n = 0; n < row.reps; n++) begin
        send_frame(row.btn);
        if (row.n_fix != 0) begin
          for (int j = 0; j < row.n_fix; j++) begin
            b.log_byte = row.fix[8*j +: 8];
            b.last_byte = (j == row.n_fix - 1);
            expected_bytes = {expected_bytes, b};
          end
        end else begin
          queue_frame_bytes();
        end
      end
    end
    calm = 1'b0;
    s_tvalid <= 1'b0;
    wait_drained();

    // Burst of random frames while the receiver is held off.
    hold_req = 1'b1;
    for (int n = 0; n < 12; n++) begin
      btn = stored_btn ^ bcle_pkg::BtnW'(1 << $urandom_range(0, bcle_pkg::RecBtn - 1)) ^
            bcle_pkg::BtnW'($urandom);
      btn = btn | (stored_btn & 16'h0000);
      send_frame(btn);
      queue_frame_bytes();
    end
    s_tvalid <= 1'b0;
    wait_drained();

    // Random frames: single-button flips, whole random words, upper-button
    // changes, repeats and long stretches without a change.
    counted = 0;
    while (counted < RandFrames) begin
      if (counted % 16 == 0) calm = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1: begin
          send_frame(stored_btn);
        end
        2: begin
          send_frame(stored_btn ^ {4'($urandom_range(1, 15)), 12'h000});
          counted++;
        end
        3: begin
          stretch = $urandom_range(10, 300);
          repeat (stretch) send_frame(stored_btn);
        end
        4, 5, 6: begin
          btn = stored_btn ^ bcle_pkg::BtnW'(1 << $urandom_range(0, bcle_pkg::RecBtn - 1));
          if ($urandom_range(0, 1)) btn = btn ^ {4'($urandom_range(0, 15)), 12'h000};
          send_frame(btn);
          counted++;
        end
        default: begin
          send_frame(bcle_pkg::BtnW'($urandom));
          counted++;
        end
      endcase
      queue_frame_bytes();
      if (counted == RandFrames / 2 && kind >= 2) begin
        s_tvalid <= 1'b0;
        wait_drained();
      end
    end
    s_tvalid <= 1'b0;

    wait_drained();
    repeat (100) @(posedge clk_i);

    $display("Sent %0d frames and checked %0d log bytes: gap nibble edges, run bytes,",
             frames_sent, beats_checked);
    $display("gap saturation, a 64-byte frame, upper-button changes and receiver stalls.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
